// ===== hdl/rcc_pkg.sv =====
// Shared types and constants of the RGB/CMYK converter.
// No dependencies; every other file of the block but rcc_stream_if refers to it by scoped names.
`default_nettype none

package rcc_pkg;

	// full-scale component value, stands for 1.0
	localparam logic [7:0] FULL = 8'd255;

	// divider datapath widths: dividend, divisor, quotient
	localparam int NUMW = 17;
	localparam int DIVW = 9;
	localparam int QW   = 8;

	// forward dividend is 2*255*(max - comp) + max
	localparam logic [NUMW-1:0] INK_SCALE2 = 17'd510;

	typedef enum logic {
		OP_RGB2CMYK = 1'b0,
		OP_CMYK2RGB = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] cyan_in;
		logic [7:0] magenta_in;
		logic [7:0] yellow_in;
		logic [7:0] black_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] cyan_out;
		logic [7:0] magenta_out;
		logic [7:0] yellow_out;
		logic [7:0] black_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} result_t;

	// classified pixel, as it waits in the queue
	typedef struct packed {
		op_t             op;
		logic            mx_zero;
		logic [7:0]      mx;
		logic [2:0][7:0] term;   // max - comp, or 255 - ink
		logic [7:0]      scale;  // 255 - black (inverse only)
	} job_t;

	// one slot of the divide pipeline
	typedef struct packed {
		op_t                  op;
		logic                 mx_zero;
		logic [7:0]           mx;
		logic [DIVW-1:0]      div;
		logic [2:0][NUMW-1:0] rem;
		logic [2:0][QW-1:0]   quo;
	} div_stage_t;

endpackage

`default_nettype wire

// ===== hdl/rcc_stream_if.sv =====
// Valid/ready stream interface used for both channels of the converter.
// The payload type is a parameter; depends on nothing else.
`default_nettype none

interface rcc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcc_front.sv =====
// Front end: takes pixels and classifies them into queue jobs.
// Depends on rcc_pkg and rcc_stream_if.
`default_nettype none

module rcc_front (
	rcc_stream_if.sink        pixel,
	input  wire logic         q_full,
	output logic              push_valid,
	output rcc_pkg::job_t     push_data
);

	logic [7:0] mx;

	always_comb begin
		mx = pixel.data.red_in;
		if (pixel.data.green_in > mx) mx = pixel.data.green_in;
		if (pixel.data.blue_in > mx) mx = pixel.data.blue_in;
	end

	always_comb begin
		push_data.op    = pixel.data.op;
		push_data.scale = rcc_pkg::FULL - pixel.data.black_in;
		if (pixel.data.op == rcc_pkg::OP_RGB2CMYK) begin
			push_data.mx      = mx;
			push_data.mx_zero = (mx == 8'd0);
			push_data.term[0] = mx - pixel.data.red_in;
			push_data.term[1] = mx - pixel.data.green_in;
			push_data.term[2] = mx - pixel.data.blue_in;
		end else begin
			push_data.mx      = 8'd0;
			push_data.mx_zero = 1'b0;
			push_data.term[0] = rcc_pkg::FULL - pixel.data.cyan_in;
			push_data.term[1] = rcc_pkg::FULL - pixel.data.magenta_in;
			push_data.term[2] = rcc_pkg::FULL - pixel.data.yellow_in;
		end
	end

	assign pixel.ready = !q_full;
	assign push_valid  = pixel.valid;

endmodule

`default_nettype wire

// ===== hdl/rcc_queue.sv =====
// Short FIFO of classified jobs between front and back end.
// Depends on rcc_pkg.
`default_nettype none

module rcc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire rcc_pkg::job_t push_data,
	output logic               full,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output rcc_pkg::job_t      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rcc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rp_q];
	assign push      = push_valid && !full;
	assign pop       = pop_ready && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== hdl/rcc_back.sv =====
// Back end: builds dividends, runs the one-bit-per-stage divider, formats results.
// Depends on rcc_pkg and rcc_stream_if.
`default_nettype none

module rcc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	input  wire rcc_pkg::job_t pop_data,
	output logic               pop_ready,
	rcc_stream_if.source       converted
);

	localparam int QW   = rcc_pkg::QW;
	localparam int NUMW = rcc_pkg::NUMW;
	localparam int DIVW = rcc_pkg::DIVW;
	localparam int NSTG = QW + 1;

	// slot 0 holds the prepared dividends, slot k+1 has quotient bits down to QW-1-k
	rcc_pkg::div_stage_t stage_s [NSTG];
	logic [NSTG-1:0]     vld_s;
	rcc_pkg::div_stage_t prep;
	rcc_pkg::div_stage_t nxt [QW];
	rcc_pkg::div_stage_t last;
	rcc_pkg::result_t    res;
	logic [2:0][15:0]    prod;
	logic                en;

	assign en        = !vld_s[NSTG-1] || converted.ready;
	assign pop_ready = en;

	always_comb begin
		prep.op      = pop_data.op;
		prep.mx_zero = pop_data.mx_zero;
		prep.mx      = pop_data.mx;
		prep.quo     = '0;
		for (int l = 0; l < 3; l++) begin
			prod[l] = 16'(pop_data.term[l]) * 16'(pop_data.scale);
		end
		if (pop_data.op == rcc_pkg::OP_RGB2CMYK) begin
			prep.div = {pop_data.mx, 1'b0};
			for (int l = 0; l < 3; l++) begin
				prep.rem[l] = NUMW'(pop_data.term[l]) * rcc_pkg::INK_SCALE2
					+ NUMW'(pop_data.mx);
			end
		end else begin
			prep.div = DIVW'(rcc_pkg::FULL);
			for (int l = 0; l < 3; l++) begin
				prep.rem[l] = NUMW'(prod[l]);
			end
		end
	end

	// restoring division, one quotient bit per stage on all three lanes
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NUMW-1:0] trial;
		assign trial = NUMW'(stage_s[k].div) << (QW - 1 - k);
		always_comb begin
			nxt[k] = stage_s[k];
			for (int l = 0; l < 3; l++) begin
				if (stage_s[k].rem[l] >= trial) begin
					nxt[k].rem[l]         = stage_s[k].rem[l] - trial;
					nxt[k].quo[l][QW-1-k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], pop_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s[0] <= prep;
			for (int k = 0; k < QW; k++) begin
				stage_s[k+1] <= nxt[k];
			end
		end
	end

	assign last = stage_s[NSTG-1];

	always_comb begin
		res = '0;
		if (last.op == rcc_pkg::OP_RGB2CMYK) begin
			res.black_out = rcc_pkg::FULL - last.mx;
			if (!last.mx_zero) begin
				res.cyan_out    = last.quo[0];
				res.magenta_out = last.quo[1];
				res.yellow_out  = last.quo[2];
			end
		end else begin
			res.red_out   = last.quo[0];
			res.green_out = last.quo[1];
			res.blue_out  = last.quo[2];
		end
	end

	assign converted.valid = vld_s[NSTG-1];
	assign converted.data  = res;

endmodule

`default_nettype wire

// ===== hdl/rgb_cmyk_converter.sv =====
// Top level of the RGB/CMYK pixel converter.
// Depends on rcc_pkg, rcc_stream_if, rcc_front, rcc_queue and rcc_back.
//
// Usage:
//   pixel     - input stream (rcc_pkg::pixel_t). op = OP_RGB2CMYK takes
//               red/green/blue; op = OP_CMYK2RGB takes cyan/magenta/yellow/black.
//   converted - result stream (rcc_pkg::result_t), one result per pixel, in
//               order. Fields of the unused color space read zero.
//   A request moves on a channel at a rising edge with valid and ready high.
//
// Throughput: one pixel per clock while converted.ready is high. The front
// end classifies the pixel (max of r/g/b, complements) and writes it to a
// short job queue; the back end builds the dividends (one 8x8 multiply per
// lane) and runs a restoring divider that resolves one quotient bit per
// stage, 8 stages, with all three lanes side by side.
// On its way to converted a pixel passes the queue write, the prep stage and
// the 8 divide stages.
//
// Stall: while a result is offered and converted.ready is low, the whole
// divide pipeline holds; the queue absorbs up to QUEUE_DEPTH more pixels
// before pixel.ready drops. Reset: arst_n clears queue pointers and pipeline
// valids; no pixel is in flight afterwards and converted.valid is low.
`default_nettype none

module rgb_cmyk_converter #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rcc_stream_if.sink   pixel,
	rcc_stream_if.source converted
);

	logic          q_full;
	logic          push_valid;
	rcc_pkg::job_t push_data;
	logic          pop_valid;
	logic          pop_ready;
	rcc_pkg::job_t pop_data;

	// classify and hand over to the queue
	rcc_front u_front (
		.pixel      (pixel),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// decouples intake from the divide pipeline
	rcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// dividend prep, divider pipeline, result formatting
	rcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.converted (converted)
	);

endmodule

`default_nettype wire

// ===== hdl/rcc_checker.sv =====
// Port-level checks of the converter's result stream, bound to the top level.
// Depends on rcc_pkg and rgb_cmyk_converter.
`default_nettype none

module rcc_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire rcc_pkg::result_t out_data
);

	logic cmyk_zero, rgb_zero;

	assign cmyk_zero = (out_data.cyan_out == 8'd0) && (out_data.magenta_out == 8'd0)
		&& (out_data.yellow_out == 8'd0) && (out_data.black_out == 8'd0);
	assign rgb_zero = (out_data.red_out == 8'd0) && (out_data.green_out == 8'd0)
		&& (out_data.blue_out == 8'd0);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// only one color space carries data in a result
	a_one_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cmyk_zero || rgb_zero))
		else $error("both color spaces nonzero");

	// a black pixel carries no colored ink
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.black_out == 8'd255 |->
			out_data.cyan_out == 8'd0 && out_data.magenta_out == 8'd0
			&& out_data.yellow_out == 8'd0)
		else $error("ink on full black");

	// in forward results the largest component leaves one ink at zero
	a_min_ink: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rgb_zero |->
			out_data.cyan_out == 8'd0 || out_data.magenta_out == 8'd0
			|| out_data.yellow_out == 8'd0)
		else $error("no ink at zero");

endmodule

bind rgb_cmyk_converter rcc_checker u_rcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (converted.valid),
	.out_ready (converted.ready),
	.out_data  (converted.data)
);

`default_nettype wire
